@@ rtl/rtt_pkg.sv @@
// ----------------------------------------------------------------------------
// Repeat timer table package
// Shared constants, opcode type and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtt_pkg;

    localparam int SLOTS_DEF   = 8;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int OP_W        = 3;
    localparam int DATA_W      = 16;
    localparam int SLOT_W      = 3;

    localparam logic KIND_FIRE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 3'd0,
        OP_SET   = 3'd1,
        OP_KILL  = 3'd2,
        OP_QUERY = 3'd3,
        OP_FLUSH = 3'd4
    } op_t;

    typedef struct packed {
        logic start;
        logic rd_en;
        logic ev_do;
        logic drain_load;
        logic resp_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic fire;
        logic pend_valid;
        logic out_free;
    } st_t;

endpackage

@@ rtl/rtt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Repeat timer table controller
// Sequences the slot scan, tracks the firing count and orders the result
// beats through the drain and response states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtt_ctrl #(
    parameter int SLOTS = rtt_pkg::SLOTS_DEF,
    parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [rtt_pkg::OP_W-1:0]  op,
    input  rtt_pkg::st_t              st,
    output rtt_pkg::cmd_t             cmd,
    output logic [IDX_W-1:0]          rd_addr,
    output logic [IDX_W-1:0]          ev_idx
);
    import rtt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_RESP  = 4'b1000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(MAX_RESULTS - 1);

    state_t            state_reg, state_next;
    logic              iss_on_reg, iss_on_next;
    logic [IDX_W-1:0]  iss_idx_reg, iss_idx_next;
    logic              ev_valid_reg, ev_valid_next;
    logic [IDX_W-1:0]  ev_idx_reg, ev_idx_next;
    logic [CNT_W-1:0]  fire_cnt_reg, fire_cnt_next;

    logic is_tick;
    logic advance;
    logic in_scan;
    logic tick_fire;
    logic cap_hit;
    logic scan_done;

    always_comb
    begin
        is_tick   = (st.op == OP_TICK);
        in_ready  = (state_reg == S_IDLE);
        in_scan   = (state_reg == S_SCAN);
        advance   = !(ev_valid_reg && is_tick && st.fire && st.pend_valid && !st.out_free);

        cmd.start      = in_valid && in_ready;
        cmd.rd_en      = in_scan && advance && iss_on_reg;
        cmd.ev_do      = in_scan && advance && ev_valid_reg;
        cmd.drain_load = (state_reg == S_DRAIN) && st.pend_valid && st.out_free;
        cmd.resp_load  = (state_reg == S_RESP) && st.out_free;

        tick_fire = cmd.ev_do && is_tick && st.fire;
        cap_hit   = tick_fire && (fire_cnt_reg == CAP_CNT);
        scan_done = cmd.ev_do && ((ev_idx_reg == LAST_IDX) || cap_hit);

        rd_addr = iss_idx_reg;
        ev_idx  = ev_idx_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        iss_on_next   = iss_on_reg;
        iss_idx_next  = iss_idx_reg;
        ev_valid_next = ev_valid_reg;
        ev_idx_next   = ev_idx_reg;
        fire_cnt_next = fire_cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    iss_on_next   = 1'b1;
                    iss_idx_next  = '0;
                    ev_valid_next = 1'b0;
                    fire_cnt_next = '0;
                    case (op_t'(op))
                        OP_TICK, OP_SET, OP_KILL, OP_QUERY: state_next = S_SCAN;
                        OP_FLUSH:                           state_next = S_RESP;
                        default:                            state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (advance)
                begin
                    ev_valid_next = iss_on_reg;
                    ev_idx_next   = iss_idx_reg;
                    if (iss_on_reg)
                    begin
                        if (iss_idx_reg == LAST_IDX)
                        begin
                            iss_on_next = 1'b0;
                        end
                        else
                        begin
                            iss_idx_next = iss_idx_reg + IDX_W'(1);
                        end
                    end
                end
                if (tick_fire)
                begin
                    fire_cnt_next = fire_cnt_reg + CNT_W'(1);
                end
                if (scan_done)
                begin
                    iss_on_next   = 1'b0;
                    ev_valid_next = 1'b0;
                    state_next    = is_tick ? S_DRAIN : S_RESP;
                end
            end
            S_DRAIN:
            begin
                if (!st.pend_valid || st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RESP:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            iss_on_reg   <= 1'b0;
            iss_idx_reg  <= '0;
            ev_valid_reg <= 1'b0;
            ev_idx_reg   <= '0;
            fire_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            iss_on_reg   <= iss_on_next;
            iss_idx_reg  <= iss_idx_next;
            ev_valid_reg <= ev_valid_next;
            ev_idx_reg   <= ev_idx_next;
            fire_cnt_reg <= fire_cnt_next;
        end
    end

endmodule

@@ rtl/rtt_datapath.sv @@
// ----------------------------------------------------------------------------
// Repeat timer table datapath
// Holds the slot memories, the active bits, the captured request, the pending
// firing beat and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtt_datapath #(
    parameter int SLOTS = rtt_pkg::SLOTS_DEF,
    parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rtt_pkg::OP_W-1:0]    op,
    input  logic [rtt_pkg::DATA_W-1:0]  now_time,
    input  logic [rtt_pkg::DATA_W-1:0]  timer_key,
    input  logic [rtt_pkg::DATA_W-1:0]  interval,
    input  logic [rtt_pkg::DATA_W-1:0]  repeat_count,
    input  rtt_pkg::cmd_t               cmd,
    input  logic [IDX_W-1:0]            rd_addr,
    input  logic [IDX_W-1:0]            ev_idx,
    output rtt_pkg::st_t                st,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        kind,
    output logic [rtt_pkg::SLOT_W-1:0]  slot,
    output logic [rtt_pkg::DATA_W-1:0]  fired_key,
    output logic                        ok,
    output logic                        last
);
    import rtt_pkg::*;

    logic [DATA_W-1:0] key_mem  [SLOTS];
    logic [DATA_W-1:0] ivl_mem  [SLOTS];
    logic [DATA_W-1:0] time_mem [SLOTS];
    logic [DATA_W-1:0] rem_mem  [SLOTS];

    logic [DATA_W-1:0] key_rd_reg;
    logic [DATA_W-1:0] ivl_rd_reg;
    logic [DATA_W-1:0] time_rd_reg;
    logic [DATA_W-1:0] rem_rd_reg;

    logic [SLOTS-1:0]  active_reg, active_next;
    op_t               op_reg;
    logic [DATA_W-1:0] now_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] ivl_reg;
    logic [DATA_W-1:0] cnt_reg;

    logic              found_valid_reg, found_valid_next;
    logic [IDX_W-1:0]  found_idx_reg, found_idx_next;
    logic              free_valid_reg, free_valid_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;

    logic              pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic [DATA_W-1:0] pend_key_reg;

    logic              out_valid_reg, out_valid_next;
    logic              kind_reg, kind_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [DATA_W-1:0] key_out_reg, key_out_next;
    logic              ok_reg, ok_next;
    logic              last_reg, last_next;
    logic              out_load;

    logic [DATA_W-1:0] elapsed;
    logic              fire;
    logic              out_free;
    logic              wr_tick;
    logic              set_ok;
    logic              wr_set;
    logic              ev_scan;
    logic              ev_active;

    always_comb
    begin
        ev_active = active_reg[ev_idx];
        elapsed   = now_reg - time_rd_reg;
        fire      = ev_active && (elapsed >= ivl_rd_reg);
        out_free  = !out_valid_reg || out_ready;
        wr_tick   = cmd.ev_do && (op_reg == OP_TICK) && fire;
        ev_scan   = cmd.ev_do && (op_reg != OP_TICK);
        set_ok    = !found_valid_reg && free_valid_reg;
        wr_set    = cmd.resp_load && (op_reg == OP_SET) && set_ok;

        st.op         = op_reg;
        st.fire       = fire;
        st.pend_valid = pend_valid_reg;
        st.out_free   = out_free;
    end

    always_comb
    begin
        active_next      = active_reg;
        found_valid_next = found_valid_reg;
        found_idx_next   = found_idx_reg;
        free_valid_next  = free_valid_reg;
        free_idx_next    = free_idx_reg;
        pend_valid_next  = pend_valid_reg;
        out_load         = 1'b0;
        kind_next        = kind_reg;
        slot_next        = slot_reg;
        key_out_next     = key_out_reg;
        ok_next          = ok_reg;
        last_next        = last_reg;

        if (cmd.start)
        begin
            found_valid_next = 1'b0;
            free_valid_next  = 1'b0;
            pend_valid_next  = 1'b0;
        end

        if (ev_scan)
        begin
            if (!found_valid_reg && ev_active && (key_rd_reg == key_reg))
            begin
                found_valid_next = 1'b1;
                found_idx_next   = ev_idx;
            end
            if (!free_valid_reg && !ev_active)
            begin
                free_valid_next = 1'b1;
                free_idx_next   = ev_idx;
            end
        end

        if (wr_tick)
        begin
            if (rem_rd_reg == DATA_W'(1))
            begin
                active_next[ev_idx] = 1'b0;
            end
            if (pend_valid_reg)
            begin
                out_load     = 1'b1;
                kind_next    = KIND_FIRE;
                slot_next    = SLOT_W'(pend_idx_reg);
                key_out_next = pend_key_reg;
                ok_next      = 1'b1;
                last_next    = 1'b0;
            end
            pend_valid_next = 1'b1;
        end

        if (cmd.drain_load)
        begin
            out_load        = 1'b1;
            kind_next       = KIND_FIRE;
            slot_next       = SLOT_W'(pend_idx_reg);
            key_out_next    = pend_key_reg;
            ok_next         = 1'b1;
            last_next       = 1'b1;
            pend_valid_next = 1'b0;
        end

        if (cmd.resp_load)
        begin
            out_load     = 1'b1;
            kind_next    = KIND_STATUS;
            last_next    = 1'b1;
            key_out_next = key_reg;
            case (op_reg)
                OP_SET:
                begin
                    ok_next   = set_ok;
                    slot_next = set_ok ? SLOT_W'(free_idx_reg) : '0;
                    if (set_ok)
                    begin
                        active_next[free_idx_reg] = 1'b1;
                    end
                end
                OP_KILL:
                begin
                    ok_next   = found_valid_reg;
                    slot_next = found_valid_reg ? SLOT_W'(found_idx_reg) : '0;
                    if (found_valid_reg)
                    begin
                        active_next[found_idx_reg] = 1'b0;
                    end
                end
                OP_FLUSH:
                begin
                    ok_next      = 1'b1;
                    slot_next    = '0;
                    key_out_next = '0;
                    active_next  = '0;
                end
                default:
                begin
                    ok_next   = found_valid_reg;
                    slot_next = found_valid_reg ? SLOT_W'(found_idx_reg) : '0;
                end
            endcase
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_set)
        begin
            key_mem[free_idx_reg]  <= key_reg;
            ivl_mem[free_idx_reg]  <= ivl_reg;
            time_mem[free_idx_reg] <= now_reg;
            rem_mem[free_idx_reg]  <= cnt_reg;
        end
        else if (wr_tick)
        begin
            time_mem[ev_idx] <= now_reg;
            if (rem_rd_reg > DATA_W'(1))
            begin
                rem_mem[ev_idx] <= rem_rd_reg - DATA_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            key_rd_reg  <= key_mem[rd_addr];
            ivl_rd_reg  <= ivl_mem[rd_addr];
            time_rd_reg <= time_mem[rd_addr];
            rem_rd_reg  <= rem_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= '0;
            op_reg          <= OP_TICK;
            found_valid_reg <= 1'b0;
            free_valid_reg  <= 1'b0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            active_reg      <= active_next;
            found_valid_reg <= found_valid_next;
            free_valid_reg  <= free_valid_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
            if (cmd.start)
            begin
                op_reg <= op_t'(op);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_idx_reg <= found_idx_next;
        free_idx_reg  <= free_idx_next;
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        key_out_reg   <= key_out_next;
        ok_reg        <= ok_next;
        last_reg      <= last_next;
        if (cmd.start)
        begin
            now_reg <= now_time;
            key_reg <= timer_key;
            ivl_reg <= interval;
            cnt_reg <= repeat_count;
        end
        if (wr_tick)
        begin
            pend_idx_reg <= ev_idx;
            pend_key_reg <= key_rd_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign slot      = slot_reg;
    assign fired_key = key_out_reg;
    assign ok        = ok_reg;
    assign last      = last_reg;

endmodule

@@ rtl/repeat_timer_table_top.sv @@
// ----------------------------------------------------------------------------
// Repeat timer table top level
// Tick, set, kill and query scan one slot per cycle, though a tick scan stalls
// while a firing beat waits for a free output register. Flush skips the scan
// and goes straight to its status answer; unknown ops return to idle with no
// result. No new request beat is taken until the last one is finished.
// Reset clears the active bits at once, so the table is empty right away.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module repeat_timer_table_top #(
    parameter int SLOTS = rtt_pkg::SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rtt_pkg::OP_W-1:0]    op,
    input  logic [rtt_pkg::DATA_W-1:0]  now_time,
    input  logic [rtt_pkg::DATA_W-1:0]  timer_key,
    input  logic [rtt_pkg::DATA_W-1:0]  interval,
    input  logic [rtt_pkg::DATA_W-1:0]  repeat_count,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        kind,
    output logic [rtt_pkg::SLOT_W-1:0]  slot,
    output logic [rtt_pkg::DATA_W-1:0]  fired_key,
    output logic                        ok,
    output logic                        last
);
    import rtt_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    cmd_t             cmd;
    st_t              st;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] ev_idx;

    rtt_ctrl #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .st       (st),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .ev_idx   (ev_idx)
    );

    rtt_datapath #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .now_time     (now_time),
        .timer_key    (timer_key),
        .interval     (interval),
        .repeat_count (repeat_count),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .ev_idx       (ev_idx),
        .st           (st),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .slot         (slot),
        .fired_key    (fired_key),
        .ok           (ok),
        .last         (last)
    );

endmodule

@@ rtl/rtt_checker.sv @@
// ----------------------------------------------------------------------------
// Repeat timer table checker
// Port-level properties of the request and result channels, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [rtt_pkg::OP_W-1:0]    op,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        kind,
    input logic [rtt_pkg::SLOT_W-1:0]  slot,
    input logic                        ok,
    input logic                        last
);
    import rtt_pkg::*;

    // A result beat that is stalled holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(slot)
            && $stable(ok) && $stable(last))
        else $error("result beat changed while stalled");

    // The block works one known request at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op <= OP_FLUSH) |=> !in_ready)
        else $error("request taken while another is in progress");

    // A status answer is always the only beat of its request.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_STATUS) |-> last)
        else $error("status beat without last");

    // A refused or missed request reports slot zero.
    a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_STATUS) && !ok |-> (slot == '0))
        else $error("failed status beat with nonzero slot");

    // Firing beats always carry ok.
    a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_FIRE) |-> ok)
        else $error("firing beat without ok");

endmodule

bind repeat_timer_table_top rtt_checker u_rtt_checker (.*);

@@ tb/timer_table_checker.sv @@
// ----------------------------------------------------------------------------
// Repeat timer table checker
// Watches both channels of the timer table. It keeps its own copy of the
// slots, predicts the results of every accepted request beat and compares
// each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timer_table_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [rtt_pkg::OP_W-1:0]    op,
    input  logic [rtt_pkg::DATA_W-1:0]  now_time,
    input  logic [rtt_pkg::DATA_W-1:0]  timer_key,
    input  logic [rtt_pkg::DATA_W-1:0]  interval,
    input  logic [rtt_pkg::DATA_W-1:0]  repeat_count,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        kind,
    input  logic [rtt_pkg::SLOT_W-1:0]  slot,
    input  logic [rtt_pkg::DATA_W-1:0]  fired_key,
    input  logic                        ok,
    input  logic                        last,
    output int                          mismatches,
    output int                          outstanding,
    output int                          beats_seen,
    output int                          fires_seen,
    output int                          answers_seen
);

    import rtt_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot_idx;
        logic [DATA_W-1:0] key;
        logic              found;
        logic              is_last;
    } timer_result_t;

    logic              slot_on     [SLOTS_DEF];
    logic [DATA_W-1:0] slot_tag    [SLOTS_DEF];
    logic [DATA_W-1:0] slot_period [SLOTS_DEF];
    logic [DATA_W-1:0] slot_stamp  [SLOTS_DEF];
    logic [DATA_W-1:0] slot_left   [SLOTS_DEF];

    timer_result_t expected_results[$];

    int err_total    = 0;
    int beat_total   = 0;
    int fire_total   = 0;
    int answer_total = 0;

    initial begin
        mismatches   = 0;
        outstanding  = 0;
        beats_seen   = 0;
        fires_seen   = 0;
        answers_seen = 0;
    end

    task automatic clear_table();
        for (int i = 0; i < SLOTS_DEF; i++) begin
            slot_on[i]     = 1'b0;
            slot_tag[i]    = '0;
            slot_period[i] = '0;
            slot_stamp[i]  = '0;
            slot_left[i]   = '0;
        end
    endtask

    function automatic int lookup_key(input logic [DATA_W-1:0] key);
        for (int i = 0; i < SLOTS_DEF; i++) begin
            if (slot_on[i] && slot_tag[i] == key)
                return i;
        end
        return -1;
    endfunction

    task automatic push_answer(input int idx, input logic [DATA_W-1:0] key, input logic found);
        timer_result_t r;
        r.kind     = KIND_STATUS;
        r.slot_idx = found ? SLOT_W'(idx) : '0;
        r.key      = key;
        r.found    = found;
        r.is_last  = 1'b1;
        expected_results.push_back(r);
    endtask

    task automatic predict_request(input logic [OP_W-1:0] code, input logic [DATA_W-1:0] now,
                                   input logic [DATA_W-1:0] key, input logic [DATA_W-1:0] ivl,
                                   input logic [DATA_W-1:0] cnt);
        timer_result_t     fired [MAX_RESULTS];
        timer_result_t     r;
        logic [DATA_W-1:0] elapsed;
        int                n;
        int                hit;
        n = 0;
        hit = -1;
        case (code)
            OP_TICK: begin
                for (int i = 0; i < SLOTS_DEF; i++) begin
                    if (n < MAX_RESULTS && slot_on[i]) begin
                        elapsed = now - slot_stamp[i];
                        if (elapsed >= slot_period[i]) begin
                            if (slot_left[i] == 16'd1)
                                slot_on[i] = 1'b0;
                            else if (slot_left[i] > 16'd1)
                                slot_left[i] = slot_left[i] - 16'd1;
                            slot_stamp[i] = now;
                            r.kind     = KIND_FIRE;
                            r.slot_idx = SLOT_W'(i);
                            r.key      = slot_tag[i];
                            r.found    = 1'b1;
                            r.is_last  = 1'b0;
                            fired[n]   = r;
                            n++;
                        end
                    end
                end
                for (int k = 0; k < n; k++) begin
                    r = fired[k];
                    r.is_last = (k == n - 1);
                    expected_results.push_back(r);
                end
            end
            OP_SET: begin
                if (lookup_key(key) < 0) begin
                    for (int i = SLOTS_DEF - 1; i >= 0; i--) begin
                        if (!slot_on[i])
                            hit = i;
                    end
                end
                if (hit >= 0) begin
                    slot_on[hit]     = 1'b1;
                    slot_tag[hit]    = key;
                    slot_period[hit] = ivl;
                    slot_left[hit]   = cnt;
                    slot_stamp[hit]  = now;
                end
                push_answer(hit, key, hit >= 0);
            end
            OP_KILL: begin
                hit = lookup_key(key);
                if (hit >= 0)
                    slot_on[hit] = 1'b0;
                push_answer(hit, key, hit >= 0);
            end
            OP_QUERY: begin
                hit = lookup_key(key);
                push_answer(hit, key, hit >= 0);
            end
            OP_FLUSH: begin
                clear_table();
                push_answer(0, '0, 1'b1);
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            err_total++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic compare_result();
        timer_result_t want;
        if (kind == KIND_FIRE)
            fire_total++;
        else
            answer_total++;
        if (expected_results.size() == 0) begin
            err_total++;
            $display({"%0t: unexpected result, expected none, ",
                      "actual kind %0d slot %0d key %h ok %0d last %0d"},
                     $time, kind, slot, fired_key, ok, last);
        end else begin
            want = expected_results.pop_front();
            check_field("kind", int'(want.kind), int'(kind));
            check_field("slot", int'(want.slot_idx), int'(slot));
            check_field("fired_key", int'(want.key), int'(fired_key));
            check_field("ok", int'(want.found), int'(ok));
            check_field("last", int'(want.is_last), int'(last));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_table();
            expected_results.delete();
        end else begin
            if (out_valid && out_ready)
                compare_result();
            if (in_valid && in_ready) begin
                beat_total++;
                predict_request(op, now_time, timer_key, interval, repeat_count);
            end
        end
        mismatches   <= err_total;
        outstanding  <= expected_results.size();
        beats_seen   <= beat_total;
        fires_seen   <= fire_total;
        answers_seen <= answer_total;
    end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Repeat timer table testbench
// Drives a directed sequence that fills, overflows, wraps and drains the
// table, then a long mix of random timer traffic with bursty requests and a
// stalling receiver. The checker beside the block predicts every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import rtt_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO   = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI   = 3'd7;
    localparam int              RANDOM_BEATS  = 250;
    localparam int              CYCLE_LIMIT   = 400000;
    localparam int              SETTLE_CYCLES = 40;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_CHOKED} rx_mode_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic [OP_W-1:0]   op           = OP_TICK;
    logic [DATA_W-1:0] now_time     = '0;
    logic [DATA_W-1:0] timer_key    = '0;
    logic [DATA_W-1:0] interval     = '0;
    logic [DATA_W-1:0] repeat_count = '0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] fired_key;
    logic              ok;
    logic              last;

    int mismatches;
    int outstanding;
    int beats_seen;
    int fires_seen;
    int answers_seen;

    int                cycle_count = 0;
    int                burst_left  = 0;
    int                rx_count    = 0;
    int                rx_hold     = 0;
    rx_mode_t          rx_mode     = RX_OPEN;
    logic [DATA_W-1:0] key_pool [12];

    repeat_timer_table_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .now_time     (now_time),
        .timer_key    (timer_key),
        .interval     (interval),
        .repeat_count (repeat_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .slot         (slot),
        .fired_key    (fired_key),
        .ok           (ok),
        .last         (last)
    );

    timer_table_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .now_time     (now_time),
        .timer_key    (timer_key),
        .interval     (interval),
        .repeat_count (repeat_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .slot         (slot),
        .fired_key    (fired_key),
        .ok           (ok),
        .last         (last),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .beats_seen   (beats_seen),
        .fires_seen   (fires_seen),
        .answers_seen (answers_seen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, outstanding);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rx_count++;
        if (rx_count % 97 == 0)
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_RANDOM: out_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: out_ready <= (rx_count % 4 == 0);
            default:
            begin
                if (rx_hold > 0)
                begin
                    rx_hold--;
                    out_ready <= 1'b0;
                end
                else
                begin
                    rx_hold = $urandom_range(4, 14);
                    out_ready <= 1'b1;
                end
            end
        endcase
    end

    task automatic send_beat(input logic [OP_W-1:0] code, input logic [DATA_W-1:0] now,
                             input logic [DATA_W-1:0] key, input logic [DATA_W-1:0] ivl,
                             input logic [DATA_W-1:0] cnt);
        int gap;
        op           <= code;
        now_time     <= now;
        timer_key    <= key;
        interval     <= ivl;
        repeat_count <= cnt;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int                sent;
        int                pick;
        logic [DATA_W-1:0] clock_ms;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] ivl;
        logic [DATA_W-1:0] cnt;

        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < 12; i++)
            key_pool[i] = DATA_W'($urandom);

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the table to overflow, fire across the time wrap, then drain it.
        send_beat(OP_FLUSH, 16'h1234, 16'hABCD, 16'h5555, 16'hAAAA);
        send_beat(OP_QUERY, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        send_beat(OP_KILL,  16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_TICK,  16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_SET,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_SET,   16'hFFF0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(OP_SET,   16'hFFF0, 16'h0000, 16'h0003, 16'h0002);
        send_beat(OP_SET,   16'hFFF0, 16'h0001, 16'h0010, 16'h0001);
        send_beat(OP_SET,   16'hFFF0, 16'h0002, 16'h0002, 16'h0002);
        for (int i = 3; i < 7; i++)
            send_beat(OP_SET, 16'hFFF0, DATA_W'(i), 16'h0005, 16'h0003);
        send_beat(OP_SET,   16'hFFF0, 16'h0007, 16'h0001, 16'h0001);
        send_beat(OP_TICK,  16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(OP_QUERY, 16'h0000, 16'h0001, 16'h0000, 16'h0000);
        send_beat(OP_SET,   16'h0000, 16'h0008, 16'h0000, 16'h0000);
        send_beat(OP_KILL,  16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        send_beat(OP_KILL,  16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        send_beat(OP_SET,   16'h7FFF, 16'hAAAA, 16'h0000, 16'hFFFF);
        send_beat(OP_TICK,  16'h8000, 16'h5555, 16'h5555, 16'h5555);
        send_beat(OP_TICK,  16'h8005, 16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_QUERY, 16'h8005, 16'h0003, 16'h0000, 16'h0000);
        send_beat(OP_QUERY, 16'h8005, 16'hAAAA, 16'h0000, 16'h0000);
        for (int i = OP_SPARE_LO; i <= OP_SPARE_HI; i++)
            send_beat(OP_W'(i), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(OP_FLUSH, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

        sent = 0;
        clock_ms = DATA_W'($urandom);
        while (sent < RANDOM_BEATS)
        begin
            pick = $urandom_range(0, 99);
            key = ($urandom_range(0, 6) == 0) ? DATA_W'($urandom)
                                               : key_pool[$urandom_range(0, 11)];
            if (pick < 40)
            begin
                if ($urandom_range(0, 19) == 0)
                    clock_ms = DATA_W'($urandom);
                else
                    clock_ms = clock_ms + DATA_W'($urandom_range(0, 6));
                send_beat(OP_TICK, clock_ms, DATA_W'($urandom), DATA_W'($urandom),
                          DATA_W'($urandom));
            end
            else if (pick < 68)
            begin
                pick = $urandom_range(0, 9);
                ivl = (pick < 7) ? DATA_W'($urandom_range(0, 12))
                    : (pick < 9) ? '0 : DATA_W'($urandom);
                pick = $urandom_range(0, 3);
                cnt = (pick < 2) ? DATA_W'($urandom_range(1, 4))
                    : (pick == 2) ? '0 : DATA_W'($urandom);
                send_beat(OP_SET, clock_ms, key, ivl, cnt);
            end
            else if (pick < 80)
                send_beat(OP_KILL, DATA_W'($urandom), key, DATA_W'($urandom), DATA_W'($urandom));
            else if (pick < 92)
                send_beat(OP_QUERY, DATA_W'($urandom), key, DATA_W'($urandom), DATA_W'($urandom));
            else if (pick < 97)
                send_beat(OP_FLUSH, DATA_W'($urandom), key, DATA_W'($urandom), DATA_W'($urandom));
            else
                send_beat(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), DATA_W'($urandom),
                          key, DATA_W'($urandom), DATA_W'($urandom));
            if (pick < 97)
            begin
                sent++;
                if (sent == RANDOM_BEATS / 2)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("Run covered %0d request beats, answered by %0d timer firings",
                 beats_seen, fires_seen);
        $display("and %0d status replies.", answers_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
rtl/rtt_pkg.sv
rtl/rtt_ctrl.sv
rtl/rtt_datapath.sv
rtl/repeat_timer_table_top.sv
rtl/rtt_checker.sv
tb/timer_table_checker.sv
tb/tb.sv
